@@ sv/lpd_pkg.sv @@
// Shared types and codes for the length-prefix deframer.
package lpd_pkg;

	localparam int CFG_W = 24;

	typedef enum logic [1:0] {
		REG_HEADER_LEN   = 2'd0,
		REG_LENGTH_WIDTH = 2'd1,
		REG_LENGTH_KIND  = 2'd2,
		REG_MAX_LENGTH   = 2'd3
	} reg_idx_t;

	localparam logic [1:0] LK_BIG    = 2'd0;
	localparam logic [1:0] LK_LITTLE = 2'd1;
	localparam logic [1:0] LK_ASCII  = 2'd2;
	localparam logic [1:0] LK_EBCDIC = 2'd3;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_SPACE  = 8'h20;
	localparam logic [7:0] EBCDIC_ZERO  = 8'hF0;
	localparam logic [7:0] EBCDIC_SPACE = 8'h40;

	localparam logic [7:0]  RST_HEADER_LEN   = 8'd0;
	localparam logic [3:0]  RST_LENGTH_WIDTH = 4'd4;
	localparam logic [1:0]  RST_LENGTH_KIND  = LK_BIG;
	localparam logic [23:0] RST_MAX_LENGTH   = 24'd65535;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0]  header_len;
		logic [3:0]  length_width;
		logic [1:0]  length_kind;
		logic [23:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} result_t;

endpackage

@@ sv/lpd_in_reg.sv @@
// Input register stage: holds one received byte until the core consumes it.
module lpd_in_reg
	import lpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       take,
	output logic       s1_valid,
	output logic [7:0] s1_byte
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       load;

	assign load     = in_valid && (!valid_s1 || take);
	assign in_stall = valid_s1 && !take;
	assign s1_valid = valid_s1;
	assign s1_byte  = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

@@ sv/lpd_core.sv @@
// Deframing state and per-byte decode of header, length field and payload.
module lpd_core
	import lpd_pkg::*;
#(
	parameter int MAX_LEN_BITS = 24
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  logic [7:0] b,
	output logic    emit,
	output result_t res
);

	localparam int LEN_W = MAX_LEN_BITS;
	localparam logic [63:0] LIMIT_MASK = (64'd1 << MAX_LEN_BITS) - 64'd1;

	phase_t          phase_q, phase_d;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic [63:0]     acc_q, acc_d;
	logic            ds_q, ds_d;
	logic            ne_q, ne_d;

	logic [3:0]       fw;
	logic [63:0]      limit;
	logic             hdr_wait;
	logic [LEN_W-1:0] idx_e;
	logic [63:0]      acc_e;
	logic             ds_e;
	logic             ne_e;
	logic [63:0]      acc_n;
	logic             ds_n;
	logic             ne_n;
	logic [7:0]       zero;
	logic [7:0]       space;
	logic [7:0]       digit;
	logic             field_more;
	logic             bad;
	logic             is_empty;
	logic [LEN_W-1:0] pay_idx;
	logic             pay_last;

	always_comb begin
		if (cfg.length_width == 4'd0) begin
			fw = 4'd1;
		end else if (cfg.length_width > 4'd8) begin
			fw = 4'd8;
		end else begin
			fw = cfg.length_width;
		end
	end

	assign limit    = 64'(cfg.max_length) & LIMIT_MASK;
	assign hdr_wait = (phase_q == PH_HEADER) && (idx_q < LEN_W'(cfg.header_len));
	assign pay_idx  = idx_q + LEN_W'(1);
	assign pay_last = pay_idx >= acc_q[LEN_W-1:0];

	// length field decode, entering from the header when needed
	always_comb begin
		if (phase_q == PH_LENGTH) begin
			idx_e = idx_q;
			acc_e = acc_q;
			ds_e  = ds_q;
			ne_e  = ne_q;
		end else begin
			idx_e = '0;
			acc_e = '0;
			ds_e  = 1'b0;
			ne_e  = 1'b0;
		end
		zero  = (cfg.length_kind == LK_ASCII) ? ASCII_ZERO : EBCDIC_ZERO;
		space = (cfg.length_kind == LK_ASCII) ? ASCII_SPACE : EBCDIC_SPACE;
		digit = b - zero;
		acc_n = acc_e;
		ds_n  = ds_e;
		ne_n  = ne_e;
		case (cfg.length_kind)
			LK_BIG: begin
				acc_n = {acc_e[55:0], b};
			end
			LK_LITTLE: begin
				acc_n = acc_e | (64'(b) << {idx_e[2:0], 3'b000});
			end
			default: begin
				if (!ne_e) begin
					if (b >= zero && b <= zero + 8'd9) begin
						acc_n = (acc_e << 3) + (acc_e << 1) + 64'(digit[3:0]);
						ds_n  = 1'b1;
					end else if (!(!ds_e && b == space)) begin
						ne_n = 1'b1;
					end
				end
			end
		endcase
		field_more = (idx_e + LEN_W'(1)) < LEN_W'(fw);
		bad        = (cfg.length_kind[1] && !ds_n) || (acc_n > limit);
		is_empty   = acc_n == 64'd0;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		acc_d   = acc_q;
		ds_d    = ds_q;
		ne_d    = ne_q;
		case (phase_q)
			PH_PAYLOAD: begin
				if (pay_last) begin
					phase_d = PH_HEADER;
					idx_d   = '0;
					acc_d   = '0;
					ds_d    = 1'b0;
					ne_d    = 1'b0;
				end else begin
					idx_d = pay_idx;
				end
			end
			default: begin
				if (hdr_wait) begin
					idx_d = idx_q + LEN_W'(1);
				end else if (field_more) begin
					phase_d = PH_LENGTH;
					idx_d   = idx_e + LEN_W'(1);
					acc_d   = acc_n;
					ds_d    = ds_n;
					ne_d    = ne_n;
				end else if (bad || is_empty) begin
					phase_d = PH_HEADER;
					idx_d   = '0;
					acc_d   = '0;
					ds_d    = 1'b0;
					ne_d    = 1'b0;
				end else begin
					phase_d = PH_PAYLOAD;
					idx_d   = '0;
					acc_d   = acc_n;
					ds_d    = 1'b0;
					ne_d    = 1'b0;
				end
			end
		endcase
	end

	// result of this byte
	always_comb begin
		emit     = 1'b0;
		res.kind = KIND_PAYLOAD;
		res.data = 8'd0;
		res.last = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				emit     = 1'b1;
				res.data = b;
				res.last = pay_last;
			end
			default: begin
				if (!hdr_wait && !field_more) begin
					if (bad) begin
						emit     = 1'b1;
						res.kind = KIND_ERROR;
						res.last = 1'b1;
					end else if (is_empty) begin
						emit     = 1'b1;
						res.kind = KIND_EMPTY;
						res.last = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			acc_q   <= '0;
			ds_q    <= 1'b0;
			ne_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			acc_q   <= acc_d;
			ds_q    <= ds_d;
			ne_q    <= ne_d;
		end
	end

endmodule

@@ sv/lpd_out_reg.sv @@
// Result register: holds one result until the receiver takes it.
module lpd_out_reg
	import lpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    res,
	output logic       ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data,
	output logic       last
);

	logic    valid_q;
	result_t res_q;

	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign kind      = res_q.kind;
	assign data      = res_q.data;
	assign last      = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

@@ sv/length_prefix_deframer_unit.sv @@
// Length-prefix deframer top level: configuration registers and stage wiring.
//
// Received bytes enter on in_valid/in_stall/in_byte, one request per byte.
// Each message is header_len skipped bytes, a length field of length_width
// bytes (big or little endian binary, ASCII or EBCDIC decimal), then payload.
// Results leave on out_valid/out_stall with kind, data and last: one per
// payload byte, one empty-message result for a zero length, or one error
// result for a bad length. Header and non-final length bytes give no result.
// A result is shown in the cycle after its byte is taken (the byte is
// decoded out of the input register and the result register loads at the
// edge that takes it). Throughput: one byte per cycle while the receiver
// does not stall, with a single decode step between the two registers.
// Reset clears both registers and returns the decoder to the header phase
// with the configuration at its reset values. When the receiver stalls the
// result register holds; one more byte may sit in the input register, and
// in_stall rises only when that byte needs the occupied result register.
// Write configuration through cfg_write/cfg_index/cfg_data while idle.
module length_prefix_deframer_unit
	import lpd_pkg::*;
#(
	parameter int MAX_LEN_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       in_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       data,
	output logic             last
);

	cfg_t    cfg_q;
	logic    s1_valid;
	logic [7:0] s1_byte;
	logic    emit;
	result_t res;
	logic    out_ready;
	logic    take;

	assign take = s1_valid && (!emit || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_len   <= RST_HEADER_LEN;
			cfg_q.length_width <= RST_LENGTH_WIDTH;
			cfg_q.length_kind  <= RST_LENGTH_KIND;
			cfg_q.max_length   <= RST_MAX_LENGTH;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_HEADER_LEN:   cfg_q.header_len   <= cfg_data[7:0];
				REG_LENGTH_WIDTH: cfg_q.length_width <= cfg_data[3:0];
				REG_LENGTH_KIND:  cfg_q.length_kind  <= cfg_data[1:0];
				REG_MAX_LENGTH:   cfg_q.max_length   <= cfg_data[23:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	lpd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.take     (take),
		.s1_valid (s1_valid),
		.s1_byte  (s1_byte)
	);

	lpd_core #(
		.MAX_LEN_BITS (MAX_LEN_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (take),
		.b      (s1_byte),
		.emit   (emit),
		.res    (res)
	);

	lpd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && emit),
		.res       (res),
		.ready     (out_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.data      (data),
		.last      (last)
	);

endmodule

@@ sv/lpd_checker.sv @@
// Port-level checks for the length-prefix deframer and their bind.
module lpd_checker
	import lpd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_write,
	input logic [1:0]       cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic             in_valid,
	input logic             in_stall,
	input logic [7:0]       in_byte,
	input logic             out_valid,
	input logic             out_stall,
	input logic [1:0]       kind,
	input logic [7:0]       data,
	input logic             last
);

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_PAYLOAD || kind == KIND_EMPTY || kind == KIND_ERROR))
		else $error("undefined result kind");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_PAYLOAD) |-> (last && data == 8'd0))
		else $error("status result without last or with data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(data)
			&& $stable(last)))
		else $error("stalled result changed");

	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && $past(!out_valid)) |-> !in_stall)
		else $error("input stalled while output side empty");

endmodule

bind length_prefix_deframer_unit lpd_checker u_lpd_checker (.*);
